// ===== hdl/sbbf_pkg.sv =====
// Shared types, constants and helpers for the scanline bright band finder.
package sbbf_pkg;

    localparam int MAX_ROW_WIDTH = 2048;
    localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
    localparam int CTR_W         = 11;
    localparam int SUM_W         = 32;
    localparam int PIX_W         = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int QUO_W         = PIX_W + 1;
    localparam int DIV_CNT_W     = $clog2(QUO_W);

    localparam logic [PIX_W-1:0] EDGE_MARK = 8'd255;
    localparam logic [PIX_W-1:0] MEAN_MAX  = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_LEVEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_EDGE_GAP = 2'd2;

    localparam logic [PIX_W-1:0] BRIGHT_RESET = 8'd200;
    localparam logic [PIX_W-1:0] DARK_RESET   = 8'd80;
    localparam logic [PIX_W-1:0] GAP_RESET    = 8'd9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CLOSE,
        S_FINAL,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic step;
        logic final_keep;
        logic div_step;
        logic close;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic step_close;
        logic fin_close;
        logic div_done;
        logic out_busy;
    } status_t;

    // column distance modulo the row width
    function automatic logic [COL_W-1:0] col_diff(input logic [COL_W-1:0] later,
                                                  input logic [COL_W-1:0] earlier);
        logic [COL_W:0] t;
        if (later >= earlier)
        begin
            t = {1'b0, later} - {1'b0, earlier};
        end
        else
        begin
            t = {1'b0, later} + (COL_W+1)'(MAX_ROW_WIDTH) - {1'b0, earlier};
        end
        return t[COL_W-1:0];
    endfunction

    function automatic logic [COL_W-1:0] abs_diff(input logic [COL_W-1:0] a,
                                                  input logic [COL_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== hdl/sbbf_ctrl.sv =====
// Controller state machine for the scanline bright band finder.
module sbbf_ctrl
    import sbbf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    last_in_row,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   last_reg, last_next;
    logic   fin_reg, fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            fin_reg   <= fin_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.step  = 1'b1;
                    last_next = last_in_row;
                    if (status.step_close)
                    begin
                        state_next = S_DIV;
                    end
                    else if (last_in_row)
                    begin
                        state_next = S_FINAL;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                cmd.close = 1'b1;
                if (fin_reg)
                begin
                    state_next = S_EMIT;
                end
                else if (last_reg)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FINAL:
            begin
                cmd.final_keep = 1'b1;
                fin_next       = 1'b1;
                state_next     = status.fin_close ? S_DIV : S_EMIT;
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    last_next  = 1'b0;
                    fin_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/sbbf_dp.sv =====
// Datapath: edge tracking, segment sums, mean divider, band test and output word.
module sbbf_dp
    import sbbf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PIX_W-1:0]     cfg_data,
    input  logic [PIX_W-1:0]     edge_value,
    input  logic [PIX_W-1:0]     gray_value,
    input  cmd_t                 cmd,
    output status_t              status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 found,
    output logic [CTR_W-1:0]     centre_column
);

    logic [PIX_W-1:0]     bright_reg, dark_reg, gap_reg;
    logic [COL_W-1:0]     col_reg, pend_edge_reg, kept_edge_reg;
    logic                 pend_valid_reg, kept_valid_reg;
    logic [SUM_W-1:0]     sum_kept_reg, sum_pend_reg;
    logic [1:0]           seg_cnt_reg;
    logic [COL_W-1:0]     w_hist_reg [2];
    logic [PIX_W-1:0]     m_hist_reg [2];
    logic [COL_W-1:0]     s_hist_reg [2];
    logic                 band_found_reg;
    logic [COL_W-1:0]     band_col_reg;
    logic [SUM_W-1:0]     div_rem_reg;
    logic [COL_W-1:0]     div_den_reg, div_start_reg;
    logic [QUO_W-1:0]     div_q_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 out_valid_reg;
    logic                 found_reg;
    logic [CTR_W-1:0]     centre_reg;

    logic                 is_edge, keep1;
    logic [COL_W-1:0]     col_step;
    logic [SUM_W-1:0]     den_sh;
    logic                 div_ge;
    logic [PIX_W-1:0]     mean;
    logic [COL_W-1:0]     half;
    logic                 band_hit;
    logic [COL_W:0]       centre_sum;

    assign is_edge  = (edge_value == EDGE_MARK);
    assign keep1    = is_edge && pend_valid_reg &&
                      (32'(col_diff(col_reg, pend_edge_reg)) > 32'(gap_reg));
    assign col_step = (32'(col_reg) + 32'd1 >= 32'(MAX_ROW_WIDTH)) ? '0 : col_reg + 1'b1;

    assign den_sh = SUM_W'(div_den_reg) << div_cnt_reg;
    assign div_ge = (div_rem_reg >= den_sh);

    always_comb
    begin
        if (div_den_reg == '0)
        begin
            mean = '0;
        end
        else if (div_q_reg[QUO_W-1])
        begin
            mean = MEAN_MAX;
        end
        else
        begin
            mean = div_q_reg[PIX_W-1:0];
        end
    end

    assign half       = w_hist_reg[1] >> 1;
    assign band_hit   = (seg_cnt_reg == 2'd2) && !band_found_reg &&
                        (m_hist_reg[1] > bright_reg) && (m_hist_reg[0] < dark_reg) &&
                        (mean < dark_reg) &&
                        (abs_diff(w_hist_reg[1], w_hist_reg[0]) < half) &&
                        (abs_diff(w_hist_reg[1], div_den_reg) < half);
    assign centre_sum = {1'b0, s_hist_reg[1]} + {1'b0, div_start_reg};

    assign status.step_close = keep1 && kept_valid_reg;
    assign status.fin_close  = pend_valid_reg && kept_valid_reg;
    assign status.div_done   = (div_cnt_reg == '0);
    assign status.out_busy   = out_valid_reg && !out_ready;

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign centre_column = centre_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg <= BRIGHT_RESET;
            dark_reg   <= DARK_RESET;
            gap_reg    <= GAP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BRIGHT_LEVEL: bright_reg <= cfg_data;
                REG_DARK_LEVEL:   dark_reg   <= cfg_data;
                REG_MIN_EDGE_GAP: gap_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // divider operands and restoring iterations
    always_ff @(posedge clk)
    begin
        if (cmd.step && keep1 && kept_valid_reg)
        begin
            div_rem_reg   <= sum_kept_reg - sum_pend_reg;
            div_den_reg   <= col_diff(pend_edge_reg, kept_edge_reg);
            div_start_reg <= kept_edge_reg;
            div_q_reg     <= '0;
            div_cnt_reg   <= DIV_CNT_W'(QUO_W - 1);
        end
        else if (cmd.final_keep && pend_valid_reg && kept_valid_reg)
        begin
            div_rem_reg   <= sum_kept_reg - sum_pend_reg;
            div_den_reg   <= col_diff(pend_edge_reg, kept_edge_reg);
            div_start_reg <= kept_edge_reg;
            div_q_reg     <= '0;
            div_cnt_reg   <= DIV_CNT_W'(QUO_W - 1);
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
            begin
                div_rem_reg <= div_rem_reg - den_sh;
            end
            div_q_reg <= {div_q_reg[QUO_W-2:0], div_ge};
            if (div_cnt_reg != '0)
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            pend_edge_reg  <= '0;
            pend_valid_reg <= 1'b0;
            kept_edge_reg  <= '0;
            kept_valid_reg <= 1'b0;
            sum_kept_reg   <= '0;
            sum_pend_reg   <= '0;
            seg_cnt_reg    <= '0;
            w_hist_reg     <= '{default: '0};
            m_hist_reg     <= '{default: '0};
            s_hist_reg     <= '{default: '0};
            band_found_reg <= 1'b0;
            band_col_reg   <= '0;
        end
        else if (cmd.step)
        begin
            if (keep1)
            begin
                kept_edge_reg  <= pend_edge_reg;
                kept_valid_reg <= 1'b1;
                sum_kept_reg   <= sum_pend_reg + SUM_W'(gray_value);
            end
            else
            begin
                sum_kept_reg <= sum_kept_reg + SUM_W'(gray_value);
            end
            if (is_edge)
            begin
                pend_edge_reg  <= col_reg;
                pend_valid_reg <= 1'b1;
                sum_pend_reg   <= SUM_W'(gray_value);
            end
            else
            begin
                sum_pend_reg <= sum_pend_reg + SUM_W'(gray_value);
            end
            col_reg <= col_step;
        end
        else if (cmd.final_keep)
        begin
            if (pend_valid_reg)
            begin
                kept_edge_reg  <= pend_edge_reg;
                kept_valid_reg <= 1'b1;
                sum_kept_reg   <= sum_pend_reg;
            end
        end
        else if (cmd.close)
        begin
            if (band_hit)
            begin
                band_found_reg <= 1'b1;
                band_col_reg   <= centre_sum[COL_W:1];
            end
            w_hist_reg[0] <= w_hist_reg[1];
            m_hist_reg[0] <= m_hist_reg[1];
            s_hist_reg[0] <= s_hist_reg[1];
            w_hist_reg[1] <= div_den_reg;
            m_hist_reg[1] <= mean;
            s_hist_reg[1] <= div_start_reg;
            if (seg_cnt_reg != 2'd2)
            begin
                seg_cnt_reg <= seg_cnt_reg + 1'b1;
            end
        end
        else if (cmd.emit)
        begin
            col_reg        <= '0;
            pend_edge_reg  <= '0;
            pend_valid_reg <= 1'b0;
            kept_edge_reg  <= '0;
            kept_valid_reg <= 1'b0;
            sum_kept_reg   <= '0;
            sum_pend_reg   <= '0;
            seg_cnt_reg    <= '0;
            w_hist_reg     <= '{default: '0};
            m_hist_reg     <= '{default: '0};
            s_hist_reg     <= '{default: '0};
            band_found_reg <= 1'b0;
            band_col_reg   <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            centre_reg    <= '0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
            found_reg     <= band_found_reg;
            centre_reg    <= band_found_reg ? CTR_W'(band_col_reg) : '0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== hdl/scanline_bright_band_finder.sv =====
// Top level of the scanline bright band finder.
// One image row enters pixel by pixel; on the row's last pixel one word comes out
// with found and the centre column of the first dark-bright-dark band. A plain
// pixel does not stall the input. A pixel that closes a segment holds the input
// while the segment mean is produced by a shared restoring divider that settles
// one quotient bit per cycle over nine bits, and while the band test then runs.
// The last pixel of a row holds the input while any final segment is divided
// and tested and the output register, which can hold a word while the next row
// starts, is loaded. Configuration words are taken at any time, meant for idle.
module scanline_bright_band_finder
    import sbbf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PIX_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PIX_W-1:0]     edge_value,
    input  logic [PIX_W-1:0]     gray_value,
    input  logic                 last_in_row,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 found,
    output logic [CTR_W-1:0]     centre_column
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    sbbf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .last_in_row (last_in_row),
        .in_ready    (in_ready),
        .status      (status),
        .cmd         (cmd)
    );

    sbbf_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .edge_value    (edge_value),
        .gray_value    (gray_value),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .centre_column (centre_column)
    );

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(centre_column))
        else $error("output word changed while stalled");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> centre_column == '0)
        else $error("centre column nonzero without a band");

    a_plain_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && edge_value != EDGE_MARK && !last_in_row |=> in_ready)
        else $error("plain pixel stalled the input");

    a_emit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !cmd.step && !cmd.close && !in_ready)
        else $error("emit overlaps other work");

endmodule
